// File: src/p1305_pkg.sv
// p1305_pkg: shared widths, key clamp masks, register indexes, controller
// states and the command/status structs of the poly1305 mac block.
// No dependencies; imported by every module of the block.
`default_nettype none

package p1305_pkg;

    // limb arithmetic
    localparam int NUM_LIMBS = 5;
    localparam int LIMB_W    = 26;
    localparam int ACC_W     = 27;              // accumulator limb, partially reduced
    localparam int H_W       = 28;              // accumulator plus message limb
    localparam int COEF_W    = 29;              // r limb or 5 * r limb
    localparam int PROD_W    = H_W + COEF_W;    // one limb product
    localparam int SUM_W     = PROD_W + 3;      // five products plus carry in
    localparam int CARRY_W   = SUM_W - LIMB_W;  // carry out of a column
    localparam int FOLD_W    = CARRY_W + 3;     // limb 0 plus 5 * carry
    localparam int COL_W     = $clog2(NUM_LIMBS);
    localparam int NUM_PASSES = 3;              // carry passes before the final compare
    localparam int PASS_W    = $clog2(NUM_PASSES);

    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(NUM_LIMBS - 1);
    localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(NUM_PASSES - 1);

    // r clamp: top 4 bits of bytes 3, 7, 11, 15 and low 2 bits of bytes 4, 8, 12
    localparam logic [63:0] CLAMP_LO = 64'h0FFF_FFFC_0FFF_FFFF;
    localparam logic [63:0] CLAMP_HI = 64'h0FFF_FFFC_0FFF_FFFC;

    // block payload widths
    localparam int WORD_W    = 64;
    localparam int BYTES_W   = 5;
    localparam int BLOCK_BYTES = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_R_LOW  = 2'd0,
        CFG_KEY_R_HIGH = 2'd1,
        CFG_KEY_S_LOW  = 2'd2,
        CFG_KEY_S_HIGH = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM_LAST,
        ST_FOLD,
        ST_FIN_PASS,
        ST_FIN_SUB,
        ST_FIN_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic             load;       // capture accumulator + padded block
        logic             mul;        // five limb products of one column
        logic [COL_W-1:0] mul_col;
        logic             sum;        // add the column products, keep carry
        logic             sum_first;  // no carry into column 0
        logic [COL_W-1:0] sum_col;
        logic             fold;       // fold top carry times 5 into limb 0
        logic             fin_pass;   // one carry pass of the final reduction
        logic             fin_first;  // first pass reads the accumulator
        logic             fin_sub;    // conditional subtract of p and packing
        logic             fin_out;    // add s, load the tag, clear accumulator
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty_item;             // block carries no message bytes
    } dp_status_t;

endpackage

`default_nettype wire

// File: src/p1305_ctrl.sv
// p1305_ctrl: sequencer of the poly1305 mac block; walks the multiply columns,
// the fold and the final reduction, and owns the handshakes.
// Depends on p1305_pkg.
`default_nettype none

module p1305_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   last_block,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    input  wire p1305_pkg::dp_status_t  status,
    output p1305_pkg::dp_cmd_t          cmd
);
    import p1305_pkg::*;

    state_t              state_reg,     state_next;
    logic [COL_W-1:0]    col_reg,       col_next;
    logic [PASS_W-1:0]   pass_reg,      pass_next;
    logic                last_reg,      last_next;
    logic                out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            pass_reg      <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            pass_reg      <= pass_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        pass_next      = pass_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    last_next = last_block;
                    if (!status.empty_item)
                    begin
                        cmd.load   = 1'b1;
                        col_next   = '0;
                        state_next = ST_MUL;
                    end
                    else if (last_block)
                    begin
                        pass_next  = '0;
                        state_next = ST_FIN_PASS;
                    end
                end
            end

            ST_MUL:
            begin
                // products of this column, sum of the previous one
                cmd.mul       = 1'b1;
                cmd.mul_col   = col_reg;
                cmd.sum       = (col_reg != '0);
                cmd.sum_col   = col_reg - COL_W'(1);
                cmd.sum_first = (col_reg == COL_W'(1));
                if (col_reg == LAST_COL)
                begin
                    state_next = ST_SUM_LAST;
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end

            ST_SUM_LAST:
            begin
                cmd.sum     = 1'b1;
                cmd.sum_col = LAST_COL;
                state_next  = ST_FOLD;
            end

            ST_FOLD:
            begin
                cmd.fold = 1'b1;
                if (last_reg)
                begin
                    pass_next  = '0;
                    state_next = ST_FIN_PASS;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_FIN_PASS:
            begin
                cmd.fin_pass  = 1'b1;
                cmd.fin_first = (pass_reg == '0);
                if (pass_reg == LAST_PASS)
                begin
                    state_next = ST_FIN_SUB;
                end
                else
                begin
                    pass_next = pass_reg + PASS_W'(1);
                end
            end

            ST_FIN_SUB:
            begin
                cmd.fin_sub = 1'b1;
                state_next  = ST_FIN_OUT;
            end

            ST_FIN_OUT:
            begin
                // wait for the tag register to be free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.fin_out    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: src/p1305_dpath.sv
// p1305_dpath: key registers, block padding, five shared limb multipliers,
// column adder with carry, final reduction and tag register.
// Depends on p1305_pkg; driven by p1305_ctrl commands.
`default_nettype none

module p1305_dpath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [p1305_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [p1305_pkg::WORD_W-1:0]        cfg_data,
    input  wire logic [p1305_pkg::WORD_W-1:0]        block_low,
    input  wire logic [p1305_pkg::WORD_W-1:0]        block_high,
    input  wire logic [p1305_pkg::BYTES_W-1:0]       block_bytes,
    input  wire p1305_pkg::dp_cmd_t                  cmd,
    output p1305_pkg::dp_status_t                    status,
    output logic [p1305_pkg::WORD_W-1:0]             tag_low,
    output logic [p1305_pkg::WORD_W-1:0]             tag_high
);
    import p1305_pkg::*;

    typedef logic [NUM_LIMBS-1:0][H_W-1:0] fin_limbs_t;

    // one carry pass, then fold the top carry times 5 into limb 0
    function automatic fin_limbs_t carry_pass(input fin_limbs_t h);
        logic [H_W:0] t;
        logic [H_W:0] c;
        fin_limbs_t   o;
        c = '0;
        for (int i = 0; i < NUM_LIMBS; i++)
        begin
            t    = {1'b0, h[i]} + c;
            c    = t >> LIMB_W;
            o[i] = H_W'(t[LIMB_W-1:0]);
        end
        o[0] = o[0] + H_W'((c << 2) + c);
        return o;
    endfunction

    // take h + 5 - 2^130 when it does not go negative, then pack to 128 bits
    function automatic logic [2*WORD_W-1:0] sub_pack(input fin_limbs_t hin);
        logic [H_W:0]      t;
        logic [H_W:0]      c;
        fin_limbs_t        g;
        fin_limbs_t        h;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        h = hin;
        c = (H_W+1)'(5);
        for (int i = 0; i < NUM_LIMBS; i++)
        begin
            t    = {1'b0, hin[i]} + c;
            c    = t >> LIMB_W;
            g[i] = H_W'(t[LIMB_W-1:0]);
        end
        if (c != '0)
        begin
            h = g;
        end
        lo = WORD_W'(h[0]) | (WORD_W'(h[1]) << 26) | (WORD_W'(h[2]) << 52);
        hi = (WORD_W'(h[2]) >> 12) | (WORD_W'(h[3]) << 14) | (WORD_W'(h[4]) << 40);
        return {hi, lo};
    endfunction

    logic [WORD_W-1:0]   key_r_low_reg, key_r_high_reg, key_s_low_reg, key_s_high_reg;

    logic [ACC_W-1:0]    acc_reg   [NUM_LIMBS];
    logic [H_W-1:0]      hsum_reg  [NUM_LIMBS];
    logic [PROD_W-1:0]   prod_reg  [NUM_LIMBS];
    logic [CARRY_W-1:0]  carry_reg;
    fin_limbs_t          fin_reg;
    logic [2*WORD_W-1:0] packed_reg;
    logic [WORD_W-1:0]   tag_low_reg, tag_high_reg;

    logic [BYTES_W-1:0]    n_sat;
    logic [2*WORD_W-1:0]   blk;
    logic [NUM_LIMBS*LIMB_W-1:0] msg_vec;
    logic [NUM_LIMBS*LIMB_W-1:0] r_vec;
    logic [LIMB_W-1:0]     r_limb [NUM_LIMBS];
    logic [COEF_W-1:0]     s_limb [NUM_LIMBS];
    logic [COEF_W-1:0]     coef   [NUM_LIMBS];
    logic [PROD_W-1:0]     mult   [NUM_LIMBS];
    logic [SUM_W-1:0]      col_sum;
    logic [FOLD_W-1:0]     fold_sum;
    fin_limbs_t            fin_src;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_r_low_reg  <= '0;
            key_r_high_reg <= '0;
            key_s_low_reg  <= '0;
            key_s_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_R_LOW:  key_r_low_reg  <= cfg_data;
                CFG_KEY_R_HIGH: key_r_high_reg <= cfg_data;
                CFG_KEY_S_LOW:  key_s_low_reg  <= cfg_data;
                CFG_KEY_S_HIGH: key_s_high_reg <= cfg_data;
                default:        key_r_low_reg  <= key_r_low_reg;
            endcase
        end
    end

    // block padding: keep the counted bytes, 0x01 right after them
    assign n_sat = (block_bytes > BYTES_W'(BLOCK_BYTES)) ? BYTES_W'(BLOCK_BYTES) : block_bytes;
    assign blk   = {block_high, block_low};
    assign status.empty_item = (block_bytes == '0);

    always_comb
    begin
        msg_vec = '0;
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            if (BYTES_W'(i) < n_sat)
            begin
                msg_vec[8*i +: 8] = blk[8*i +: 8];
            end
            if (BYTES_W'(i) == n_sat)
            begin
                msg_vec[8*i] = 1'b1;
            end
        end
        if (n_sat == BYTES_W'(BLOCK_BYTES))
        begin
            msg_vec[8*BLOCK_BYTES] = 1'b1;
        end
    end

    // clamped r and 5 * r limbs
    assign r_vec = {2'b00, key_r_high_reg & CLAMP_HI, key_r_low_reg & CLAMP_LO};

    always_comb
    begin
        for (int i = 0; i < NUM_LIMBS; i++)
        begin
            r_limb[i] = r_vec[LIMB_W*i +: LIMB_W];
            s_limb[i] = (COEF_W'(r_limb[i]) << 2) + COEF_W'(r_limb[i]);
        end
    end

    // multiplier k takes row k of column j: r[j-k], or 5 * r wrapped around
    always_comb
    begin
        for (int k = 0; k < NUM_LIMBS; k++)
        begin
            coef[k] = '0;
            for (int j = 0; j < NUM_LIMBS; j++)
            begin
                if (cmd.mul_col == COL_W'(j))
                begin
                    if (k <= j)
                    begin
                        coef[k] = COEF_W'(r_limb[(j - k + NUM_LIMBS) % NUM_LIMBS]);
                    end
                    else
                    begin
                        coef[k] = s_limb[(j - k + NUM_LIMBS) % NUM_LIMBS];
                    end
                end
            end
            mult[k] = PROD_W'(hsum_reg[k]) * PROD_W'(coef[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_LIMBS; i++)
        begin
            if (cmd.load)
            begin
                hsum_reg[i] <= H_W'(acc_reg[i]) + H_W'(msg_vec[LIMB_W*i +: LIMB_W]);
            end
            if (cmd.mul)
            begin
                prod_reg[i] <= mult[i];
            end
        end
    end

    // column sum and fold
    always_comb
    begin
        col_sum = cmd.sum_first ? '0 : SUM_W'(carry_reg);
        for (int i = 0; i < NUM_LIMBS; i++)
        begin
            col_sum = col_sum + SUM_W'(prod_reg[i]);
        end
    end

    assign fold_sum = FOLD_W'(acc_reg[0][LIMB_W-1:0])
                    + (FOLD_W'(carry_reg) << 2) + FOLD_W'(carry_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            carry_reg <= col_sum[SUM_W-1:LIMB_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LIMBS; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (cmd.fin_out)
        begin
            for (int i = 0; i < NUM_LIMBS; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (cmd.fold)
        begin
            acc_reg[0] <= ACC_W'(fold_sum[LIMB_W-1:0]);
            acc_reg[1] <= acc_reg[1] + ACC_W'(fold_sum[FOLD_W-1:LIMB_W]);
        end
        else if (cmd.sum)
        begin
            acc_reg[cmd.sum_col] <= ACC_W'(col_sum[LIMB_W-1:0]);
        end
    end

    // final reduction
    always_comb
    begin
        for (int i = 0; i < NUM_LIMBS; i++)
        begin
            fin_src[i] = cmd.fin_first ? H_W'(acc_reg[i]) : fin_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin_pass)
        begin
            fin_reg <= carry_pass(fin_src);
        end
        if (cmd.fin_sub)
        begin
            packed_reg <= sub_pack(fin_reg);
        end
        if (cmd.fin_out)
        begin
            {tag_high_reg, tag_low_reg} <= packed_reg + {key_s_high_reg, key_s_low_reg};
        end
    end

    assign tag_low  = tag_low_reg;
    assign tag_high = tag_high_reg;

endmodule

`default_nettype wire

// File: src/poly1305_mac_top.sv
// poly1305_mac_top: top level of the poly1305 one-time authenticator.
// Depends on p1305_pkg, p1305_ctrl and p1305_dpath.
//
// Computes a poly1305 tag over a message fed as blocks of up to 16 bytes.
// Load the 32-byte key first through the config channel (index 0 and 1: the
// r half, clamped internally; index 2 and 3: the s pad, all little endian),
// and only while the block is idle. Each input transaction brings one block:
// block_low/block_high hold bytes 0..15, block_bytes the count (values above
// 16 count as 16, bytes past the count are ignored), last_block marks the
// end of the message. One output transaction with the 16-byte tag follows
// every last block; the accumulator is then cleared for the next message.
// A block with zero bytes absorbs nothing, so an empty message gives s.
// A block with data runs from its transaction to the next ready through
// the accept, five columns through five shared 28x29 limb multipliers,
// the last column sum and the carry fold. The last block adds three carry
// passes, the compare against p and the add of s before the tag is valid;
// an empty block keeps the input ready, or runs only those final steps if last.
// The tag sits in its own register, so the next message can start while the
// tag waits; a new tag waits only if the previous one has not been taken.
// The config channel is always ready.
`default_nettype none

module poly1305_mac_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // config write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [p1305_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [p1305_pkg::WORD_W-1:0]       cfg_data,
    // message block channel
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [p1305_pkg::WORD_W-1:0]       block_low,
    input  wire logic [p1305_pkg::WORD_W-1:0]       block_high,
    input  wire logic [p1305_pkg::BYTES_W-1:0]      block_bytes,
    input  wire logic                               last_block,
    // tag channel
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [p1305_pkg::WORD_W-1:0]            tag_low,
    output logic [p1305_pkg::WORD_W-1:0]            tag_high
);
    import p1305_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       cfg_we;

    // key registers take a write in any cycle
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // sequencer: handshakes, column and pass counters
    p1305_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .last_block (last_block),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // arithmetic: padding, limb multiply, reduction, tag register
    p1305_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .block_low   (block_low),
        .block_high  (block_high),
        .block_bytes (block_bytes),
        .cmd         (cmd),
        .status      (status),
        .tag_low     (tag_low),
        .tag_high    (tag_high)
    );

endmodule

`default_nettype wire

// File: src/p1305_chk.sv
// p1305_chk: port-level checks of poly1305_mac_top, attached by bind.
// Depends on poly1305_mac_top and p1305_pkg.
`default_nettype none

module p1305_chk (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_ready,
    input  wire logic [p1305_pkg::BYTES_W-1:0]      block_bytes,
    input  wire logic                               last_block,
    input  wire logic                               out_valid,
    input  wire logic                               out_ready,
    input  wire logic [p1305_pkg::WORD_W-1:0]       tag_low,
    input  wire logic [p1305_pkg::WORD_W-1:0]       tag_high
);
    import p1305_pkg::*;

    // a waiting tag holds
    a_tag_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tag_low) && $stable(tag_high))
        else $error("tag changed or dropped while stalled");

    // a block with data, or a last block, keeps the block busy next cycle
    a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (block_bytes != '0 || last_block) |=> !in_ready)
        else $error("ready right after a block that needs work");

    // an empty block that is not last is absorbed at once
    a_empty_passes: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && block_bytes == '0 && !last_block |=> in_ready)
        else $error("empty block stalled the input");

    // a new tag only appears out of the busy final reduction
    a_tag_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("tag raised while the input was open");

endmodule

bind poly1305_mac_top p1305_chk u_p1305_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .block_bytes (block_bytes),
    .last_block  (last_block),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .tag_low     (tag_low),
    .tag_high    (tag_high)
);

`default_nettype wire

// File: verif/tb_poly1305_mac_top.sv
`timescale 1ns / 100ps
// tb_poly1305_mac_top: self-checking testbench for the poly1305 mac block.
// Depends on p1305_pkg and poly1305_mac_top; an in-bench limb-level tag predictor checks every tag.

module tb_poly1305_mac_top;
    import p1305_pkg::*;

    // timing knobs
    localparam int SETTLE_CYCLES   = 24;        // longer than the work of a last block
    localparam int TAG_HOLD_CYCLES = 400;       // long receiver hold-off
    localparam int RUN_LIMIT_NS    = 5_000_000; // watchdog, far above the slowest run
    localparam int PHASE_ITEMS     = 85;        // random blocks per key phase

    // predictor arithmetic works on five 64-bit limb slots, like the block's column math
    localparam logic [63:0] LIMB_MASK = 64'h3FF_FFFF;
    typedef logic [NUM_LIMBS-1:0][63:0] limb_vec_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [WORD_W-1:0]     cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [WORD_W-1:0]     block_low;
    logic [WORD_W-1:0]     block_high;
    logic [BYTES_W-1:0]    block_bytes;
    logic                  last_block;
    logic                  out_valid;
    logic                  out_ready;
    logic [WORD_W-1:0]     tag_low;
    logic [WORD_W-1:0]     tag_high;

    // key copy and accumulator of the predictor
    logic [WORD_W-1:0]     key_r_lo;
    logic [WORD_W-1:0]     key_r_hi;
    logic [WORD_W-1:0]     key_s_lo;
    logic [WORD_W-1:0]     key_s_hi;
    logic [ACC_W-1:0]      acc_limb [NUM_LIMBS];

    // tags still owed by the block, oldest first
    logic [2*WORD_W-1:0]   pending_tags [$];
    logic [2*WORD_W-1:0]   next_tag;
    int unsigned           mismatches = 0;

    // hold_tags: receiver pauses for TAG_HOLD_CYCLES; quiet: no idle gaps on either side
    bit                    hold_tags = 1'b0;
    bit                    quiet     = 1'b0;

    poly1305_mac_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .block_low   (block_low),
        .block_high  (block_high),
        .block_bytes (block_bytes),
        .last_block  (last_block),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tag_low     (tag_low),
        .tag_high    (tag_high)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // tag predictor
    // ------------------------------------------------------------------

    // 130-bit value as five 26-bit limbs, top holds bits 128 and up
    function automatic limb_vec_t to_limbs(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [1:0] top);
        limb_vec_t l;
        l[0] = lo & LIMB_MASK;
        l[1] = (lo >> 26) & LIMB_MASK;
        l[2] = ((lo >> 52) | (hi << 12)) & LIMB_MASK;
        l[3] = (hi >> 14) & LIMB_MASK;
        l[4] = (hi >> 40) | (64'(top) << 24);
        return l;
    endfunction

    // acc = (acc + m) * r mod 2^130-5, partially reduced
    function automatic void acc_mul_r(input limb_vec_t m);
        limb_vec_t   r;
        limb_vec_t   r5;
        limb_vec_t   h;
        limb_vec_t   d;
        logic [63:0] c;
        r = to_limbs(key_r_lo & CLAMP_LO, key_r_hi & CLAMP_HI, 2'b00);
        for (int i = 0; i < NUM_LIMBS; i++)
        begin
            r5[i] = r[i] * 64'd5;
            h[i]  = 64'(acc_limb[i]) + m[i];
        end
        // columns above limb 4 wrap around with a factor of 5
        d[0] = h[0]*r[0]  + h[1]*r5[4] + h[2]*r5[3] + h[3]*r5[2] + h[4]*r5[1];
        d[1] = h[0]*r[1]  + h[1]*r[0]  + h[2]*r5[4] + h[3]*r5[3] + h[4]*r5[2];
        d[2] = h[0]*r[2]  + h[1]*r[1]  + h[2]*r[0]  + h[3]*r5[4] + h[4]*r5[3];
        d[3] = h[0]*r[3]  + h[1]*r[2]  + h[2]*r[1]  + h[3]*r[0]  + h[4]*r5[4];
        d[4] = h[0]*r[4]  + h[1]*r[3]  + h[2]*r[2]  + h[3]*r[1]  + h[4]*r[0];
        c = '0;
        for (int i = 0; i < NUM_LIMBS; i++)
        begin
            d[i] = d[i] + c;
            h[i] = d[i] & LIMB_MASK;
            c    = d[i] >> 26;
        end
        // fold the top carry into limb 0, one more step into limb 1
        h[0] = h[0] + c * 64'd5;
        c    = h[0] >> 26;
        h[0] = h[0] & LIMB_MASK;
        h[1] = h[1] + c;
        for (int i = 0; i < NUM_LIMBS; i++)
            acc_limb[i] = h[i][ACC_W-1:0];
    endfunction

    // full reduction, conditional subtract of p, then add s mod 2^128
    function automatic logic [127:0] acc_tag();
        limb_vec_t   h;
        limb_vec_t   g;
        logic [63:0] c;
        logic [63:0] lo;
        logic [63:0] hi;
        for (int i = 0; i < NUM_LIMBS; i++)
            h[i] = 64'(acc_limb[i]);
        for (int p = 0; p < NUM_PASSES; p++)
        begin
            c = '0;
            for (int i = 0; i < NUM_LIMBS; i++)
            begin
                h[i] = h[i] + c;
                c    = h[i] >> 26;
                h[i] = h[i] & LIMB_MASK;
            end
            h[0] = h[0] + c * 64'd5;
        end
        // h + 5 overflowing 2^130 means h >= p
        c = 64'd5;
        for (int i = 0; i < NUM_LIMBS; i++)
        begin
            g[i] = h[i] + c;
            c    = g[i] >> 26;
            g[i] = g[i] & LIMB_MASK;
        end
        if (c != 0)
            h = g;
        lo = h[0] | (h[1] << 26) | (h[2] << 52);
        hi = (h[2] >> 12) | (h[3] << 14) | (h[4] << 40);
        return {hi, lo} + {key_s_hi, key_s_lo};
    endfunction

    // one accepted block: pad, absorb, and queue the tag on the last one
    function automatic void take_block(input logic [63:0] lo_in, input logic [63:0] hi_in,
                                       input logic [BYTES_W-1:0] nbytes, input logic last);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [1:0]  top;
        int unsigned n;
        lo  = lo_in;
        hi  = hi_in;
        top = 2'b00;
        n   = (nbytes > BLOCK_BYTES) ? BLOCK_BYTES : nbytes;
        if (n != 0)
        begin
            // drop bytes past the count, 0x01 pad byte right after the data
            if (n < 8)
            begin
                lo = (lo & ((64'd1 << (8 * n)) - 64'd1)) | (64'd1 << (8 * n));
                hi = '0;
            end
            else if (n < 16)
                hi = (hi & ((64'd1 << (8 * (n - 8))) - 64'd1)) | (64'd1 << (8 * (n - 8)));
            else
                top = 2'b01;
            acc_mul_r(to_limbs(lo, hi, top));
        end
        if (last)
        begin
            pending_tags.push_back(acc_tag());
            for (int i = 0; i < NUM_LIMBS; i++)
                acc_limb[i] = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (quiet)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // drop in_valid for a gap of length n; n = 0 keeps the channel streaming
    task automatic in_gap(input int unsigned n);
        if (n != 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // offer one block and hold it until the transaction completes, then idle a while
    task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [BYTES_W-1:0] nbytes, input logic last);
        in_valid    <= 1'b1;
        block_low   <= lo;
        block_high  <= hi;
        block_bytes <= nbytes;
        last_block  <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        take_block(lo, hi, nbytes, last);
        in_gap(pick_gap());
    endtask

    // one config transaction; the block is idle whenever this runs
    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_KEY_R_LOW:  key_r_lo = value;
            CFG_KEY_R_HIGH: key_r_hi = value;
            CFG_KEY_S_LOW:  key_s_lo = value;
            CFG_KEY_S_HIGH: key_s_hi = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_key(input logic [63:0] r_lo, input logic [63:0] r_hi,
                            input logic [63:0] s_lo, input logic [63:0] s_hi);
        write_reg(CFG_KEY_R_LOW,  r_lo);
        write_reg(CFG_KEY_R_HIGH, r_hi);
        write_reg(CFG_KEY_S_LOW,  s_lo);
        write_reg(CFG_KEY_S_HIGH, s_hi);
    endtask

    // wait for every owed tag, then let a block without a tag finish its multiply
    task automatic settle();
        in_gap(1);
        while (pending_tags.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // key still at reset: empty message and a full block both give a zero tag
    task automatic test_reset_key();
        send_block(rand_word(), rand_word(), 5'd0, 1'b1);
        send_block(rand_word(), rand_word(), 5'd16, 1'b1);
        settle();
    endtask

    // published 34-byte vector; junk above the count in the short tail block
    task automatic test_rfc_vector();
        load_key(64'h336d5557_78bed685, 64'ha806d542_fe52447f,
                 64'hfdb20dfb_8a800301, 64'h1bf54941_aff6bf4a);
        send_block(64'h72676f74_70797243, 64'h6f462063_69687061, 5'd16, 1'b0);
        send_block(64'h65736552_206d7572, 64'h6f724720_68637261, 5'd16, 1'b0);
        send_block(64'hdeadbeef_a5a57075, 64'hffffffff_ffffffff, 5'd2, 1'b1);
        settle();
    endtask

    // all-ones key (largest clamped r, s wraps mod 2^128), every byte-count boundary
    task automatic test_length_extremes();
        logic [BYTES_W-1:0] counts [9];
        counts = '{5'd0, 5'd1, 5'd7, 5'd8, 5'd9, 5'd15, 5'd16, 5'd17, 5'd31};
        load_key('1, '1, '1, '1);
        send_block('1, '1, 5'd0, 1'b1);             // empty message, tag is s
        foreach (counts[i])
            send_block('1, '1, counts[i], 1'b0);
        send_block('1, '1, 5'd31, 1'b1);            // count saturates to 16
        send_block('0, '0, 5'd16, 1'b1);            // all-zero data
        settle();
    endtask

    // r changes between blocks of one message, s just before the last one
    task automatic test_key_change_mid_message();
        load_key(rand_word(), rand_word(), rand_word(), rand_word());
        send_block(rand_word(), rand_word(), 5'd16, 1'b0);
        settle();
        write_reg(CFG_KEY_R_LOW,  rand_word());
        write_reg(CFG_KEY_R_HIGH, rand_word());
        send_block(rand_word(), rand_word(), 5'd16, 1'b0);
        settle();
        write_reg(CFG_KEY_S_LOW,  rand_word());
        write_reg(CFG_KEY_S_HIGH, rand_word());
        send_block(rand_word(), rand_word(), 5'd11, 1'b1);
        settle();
    endtask

    // well-formed messages with random content, plus some malformed blocks
    task automatic test_random_messages();
        int unsigned        items;
        int unsigned        msg_len;
        logic [BYTES_W-1:0] nbytes;
        logic               last;
        for (int phase = 0; phase < 4; phase++)
        begin
            // phase 1: largest r and no idling; phase 2: all-ones s
            load_key((phase == 1) ? '1 : rand_word(), (phase == 1) ? '1 : rand_word(),
                     (phase == 2) ? '1 : rand_word(), (phase == 2) ? '1 : rand_word());
            quiet = (phase == 1);
            items = 0;
            while (items < PHASE_ITEMS)
            begin
                msg_len = $urandom_range(1, 6);
                for (int k = 0; k < msg_len; k++)
                begin
                    last   = (k == msg_len - 1);
                    nbytes = last ? BYTES_W'($urandom_range(0, 16)) : 5'd16;
                    if ($urandom_range(9) == 0)
                    begin
                        // malformed: any count, random end mark
                        nbytes = BYTES_W'($urandom_range(0, 31));
                        last   = 1'($urandom_range(1));
                    end
                    send_block(rand_word(), rand_word(), nbytes, last);
                    items++;
                end
            end
            quiet = 1'b0;
            settle();
        end
    endtask

    // receiver stops for a long time while one-block messages stream in back to back
    task automatic test_tag_backpressure();
        load_key(rand_word(), rand_word(), rand_word(), rand_word());
        quiet     = 1'b1;
        hold_tags = 1'b1;
        for (int k = 0; k < 30; k++)
            send_block(rand_word(), rand_word(), BYTES_W'($urandom_range(0, 16)), 1'b1);
        quiet = 1'b0;
        settle();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_KEY_R_LOW;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        block_low   <= '0;
        block_high  <= '0;
        block_bytes <= '0;
        last_block  <= 1'b0;
        // predictor starts from the reset key and an empty accumulator
        key_r_lo = '0;
        key_r_hi = '0;
        key_s_lo = '0;
        key_s_hi = '0;
        for (int i = 0; i < NUM_LIMBS; i++)
            acc_limb[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_key();
        test_rfc_vector();
        test_length_extremes();
        test_key_change_mid_message();
        test_random_messages();
        test_tag_backpressure();
        settle();

        if (mismatches == 0)
            $display("poly1305_mac_top verification clean");
        else
            $display("poly1305_mac_top verification failed");
        $finish;
    end

    // tag receiver: random stalls, one long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            if (hold_tags)
            begin
                out_ready <= 1'b0;
                repeat (TAG_HOLD_CYCLES) @(posedge clk);
                hold_tags = 1'b0;
            end
            else
            begin
                int unsigned stall;
                stall = pick_gap();
                if (stall != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // every tag transaction is matched against the oldest predicted tag
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_tags.size() == 0)
            begin
                mismatches++;
                $display("%0t: tag with none expected, actual %h_%h",
                         $time, tag_high, tag_low);
            end
            else
            begin
                next_tag = pending_tags.pop_front();
                if (tag_low !== next_tag[63:0])
                begin
                    mismatches++;
                    $display("%0t: tag_low expected %h actual %h",
                             $time, next_tag[63:0], tag_low);
                end
                if (tag_high !== next_tag[127:64])
                begin
                    mismatches++;
                    $display("%0t: tag_high expected %h actual %h",
                             $time, next_tag[127:64], tag_high);
                end
            end
        end
    end

    // watchdog for a hung handshake
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("poly1305_mac_top verification failed");
        $finish;
    end

endmodule
